/* design/solar_to_lunar_date_macros.svh */
// ----------------------------------------------------------------------------
// Solar to lunar date assertion macros
// Shared concurrent assertion forms for the date converter.
// ----------------------------------------------------------------------------
`ifndef SOLAR_TO_LUNAR_DATE_MACROS_SVH
`define SOLAR_TO_LUNAR_DATE_MACROS_SVH

// clocked check, off while in reset
`define S2L_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check, live through reset
`define S2L_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/s2l_pkg.sv */
// ----------------------------------------------------------------------------
// s2l_pkg
// Constants, tables and helpers for the solar to lunar date converter.
// ----------------------------------------------------------------------------
package s2l_pkg;

  localparam int unsigned FIRST_YEAR = 1900;
  localparam int unsigned YEAR_COUNT = 201;
  localparam int unsigned LAST_YEAR  = FIRST_YEAR + YEAR_COUNT - 1;
  localparam int unsigned EPOCH_DAY  = 30;
  localparam int unsigned BASE_DAYS  = 348;
  localparam int unsigned YC_BIAS    = (FIRST_YEAR - 4) % 60;

  typedef enum logic [2:0] {
    JOB_KILO,
    JOB_HUND,
    JOB_MCYC,
    JOB_DCYC,
    JOB_WDAY,
    JOB_YCYC
  } job_e;

  // bit 16 long leap month, bits 15..4 long months 1..12, bits 3..0 leap month
  localparam logic [16:0] YEAR_INFO [YEAR_COUNT] = '{
    17'h04bd8,17'h04ae0,17'h0a570,17'h054d5,17'h0d260,17'h0d950,17'h16554,17'h056a0,
    17'h09ad0,17'h055d2,
    17'h04ae0,17'h0a5b6,17'h0a4d0,17'h0d250,17'h1d255,17'h0b540,17'h0d6a0,17'h0ada2,
    17'h095b0,17'h14977,
    17'h04970,17'h0a4b0,17'h0b4b5,17'h06a50,17'h06d40,17'h1ab54,17'h02b60,17'h09570,
    17'h052f2,17'h04970,
    17'h06566,17'h0d4a0,17'h0ea50,17'h06e95,17'h05ad0,17'h02b60,17'h186e3,17'h092e0,
    17'h1c8d7,17'h0c950,
    17'h0d4a0,17'h1d8a6,17'h0b550,17'h056a0,17'h1a5b4,17'h025d0,17'h092d0,17'h0d2b2,
    17'h0a950,17'h0b557,
    17'h06ca0,17'h0b550,17'h15355,17'h04da0,17'h0a5b0,17'h14573,17'h052b0,17'h0a9a8,
    17'h0e950,17'h06aa0,
    17'h0aea6,17'h0ab50,17'h04b60,17'h0aae4,17'h0a570,17'h05260,17'h0f263,17'h0d950,
    17'h05b57,17'h056a0,
    17'h096d0,17'h04dd5,17'h04ad0,17'h0a4d0,17'h0d4d4,17'h0d250,17'h0d558,17'h0b540,
    17'h0b6a0,17'h195a6,
    17'h095b0,17'h049b0,17'h0a974,17'h0a4b0,17'h0b27a,17'h06a50,17'h06d40,17'h0af46,
    17'h0ab60,17'h09570,
    17'h04af5,17'h04970,17'h064b0,17'h074a3,17'h0ea50,17'h06b58,17'h055c0,17'h0ab60,
    17'h096d5,17'h092e0,
    17'h0c960,17'h0d954,17'h0d4a0,17'h0da50,17'h07552,17'h056a0,17'h0abb7,17'h025d0,
    17'h092d0,17'h0cab5,
    17'h0a950,17'h0b4a0,17'h0baa4,17'h0ad50,17'h055d9,17'h04ba0,17'h0a5b0,17'h15176,
    17'h052b0,17'h0a930,
    17'h07954,17'h06aa0,17'h0ad50,17'h05b52,17'h04b60,17'h0a6e6,17'h0a4e0,17'h0d260,
    17'h0ea65,17'h0d530,
    17'h05aa0,17'h076a3,17'h096d0,17'h04afb,17'h04ad0,17'h0a4d0,17'h1d0b6,17'h0d250,
    17'h0d520,17'h0dd45,
    17'h0b5a0,17'h056d0,17'h055b2,17'h049b0,17'h0a577,17'h0a4b0,17'h0aa50,17'h1b255,
    17'h06d20,17'h0ada0,
    17'h14b63,17'h09370,17'h049f8,17'h04970,17'h064b0,17'h168a6,17'h0ea50,17'h06b20,
    17'h1a6c4,17'h0aae0,
    17'h0a2e0,17'h0d2e3,17'h0c960,17'h0d557,17'h0d4a0,17'h0da50,17'h05d55,17'h056a0,
    17'h0a6d0,17'h055d4,
    17'h052d0,17'h0a9b8,17'h0a950,17'h0b4a0,17'h0b6a6,17'h0ad50,17'h055a0,17'h0aba4,
    17'h0a5b0,17'h052b0,
    17'h0b273,17'h06930,17'h07337,17'h06aa0,17'h0ad50,17'h14b55,17'h04b60,17'h0a570,
    17'h054e4,17'h0d160,
    17'h0e968,17'h0d520,17'h0daa0,17'h16aa6,17'h056d0,17'h04ae0,17'h0a9d4,17'h0a2d0,
    17'h0d150,17'h0f252,
    17'h0d520
  };

  // six 20-bit groups a year, first group in the top bits; each group read
  // in decimal gives four term days split 1,2,1,2 digits
  localparam logic [119:0] TERM_TEXT [YEAR_COUNT] = '{
    120'h9778397bd097c36b0b6fc9274c91aa, 120'h97b6b97bd19801ec9210c965cc920e,
    120'h97bcf97c3598082c95f8c965cc920f, 120'h97bd0b06bdb0722c965ce1cfcc920f,
    120'hb027097bd097c36b0b6fc9274c91aa, 120'h97b6b97bd19801ec9210c965cc920e,
    120'h97bcf97c359801ec95f8c965cc920f, 120'h97bd0b06bdb0722c965ce1cfcc920f,
    120'hb027097bd097c36b0b6fc9274c91aa, 120'h97b6b97bd19801ec9210c965cc920e,
    120'h97bcf97c359801ec95f8c965cc920f, 120'h97bd0b06bdb0722c965ce1cfcc920f,
    120'hb027097bd097c36b0b6fc9274c91aa, 120'h9778397bd19801ec9210c965cc920e,
    120'h97b6b97bd19801ec95f8c965cc920f, 120'h97bd09801d98082c95f8e1cfcc920f,
    120'h97bd097bd097c36b0b6fc9210c8dc2, 120'h9778397bd197c36c9210c9274c91aa,
    120'h97b6b97bd19801ec95f8c965cc920e, 120'h97bd09801d98082c95f8e1cfcc920f,
    120'h97bd097bd097c36b0b6fc9210c8dc2, 120'h9778397bd097c36c9210c9274c91aa,
    120'h97b6b97bd19801ec95f8c965cc920e, 120'h97bcf97c3598082c95f8e1cfcc920f,
    120'h97bd097bd097c36b0b6fc9210c8dc2, 120'h9778397bd097c36c9210c9274c91aa,
    120'h97b6b97bd19801ec9210c965cc920e, 120'h97bcf97c3598082c95f8c965cc920f,
    120'h97bd097bd097c35b0b6fc920fb0722, 120'h9778397bd097c36b0b6fc9274c91aa,
    120'h97b6b97bd19801ec9210c965cc920e, 120'h97bcf97c3598082c95f8c965cc920f,
    120'h97bd097bd097c35b0b6fc920fb0722, 120'h9778397bd097c36b0b6fc9274c91aa,
    120'h97b6b97bd19801ec9210c965cc920e, 120'h97bcf97c359801ec95f8c965cc920f,
    120'h97bd097bd097c35b0b6fc920fb0722, 120'h9778397bd097c36b0b6fc9274c91aa,
    120'h97b6b97bd19801ec9210c965cc920e, 120'h97bcf97c359801ec95f8c965cc920f,
    120'h97bd097bd097c35b0b6fc920fb0722, 120'h9778397bd097c36b0b6fc9274c91aa,
    120'h97b6b97bd19801ec9210c965cc920e, 120'h97bcf97c359801ec95f8c965cc920f,
    120'h97bd097bd07f595b0b6fc920fb0722, 120'h9778397bd097c36b0b6fc9210c8dc2,
    120'h9778397bd19801ec9210c9274c920e, 120'h97b6b97bd19801ec95f8c965cc920f,
    120'h97bd07f5307f595b0b0bc920fb0722, 120'h7f0e397bd097c36b0b6fc9210c8dc2,
    120'h9778397bd097c36c9210c9274c920e, 120'h97b6b97bd19801ec95f8c965cc920f,
    120'h97bd07f5307f595b0b0bc920fb0722, 120'h7f0e397bd097c36b0b6fc9210c8dc2,
    120'h9778397bd097c36c9210c9274c91aa, 120'h97b6b97bd19801ec9210c965cc920e,
    120'h97bd07f1487f595b0b0bc920fb0722, 120'h7f0e397bd097c36b0b6fc9210c8dc2,
    120'h9778397bd097c36b0b6fc9274c91aa, 120'h97b6b97bd19801ec9210c965cc920e,
    120'h97bcf7f1487f595b0b0bb0b6fb0722, 120'h7f0e397bd097c35b0b6fc920fb0722,
    120'h9778397bd097c36b0b6fc9274c91aa, 120'h97b6b97bd19801ec9210c965cc920e,
    120'h97bcf7f1487f595b0b0bb0b6fb0722, 120'h7f0e397bd097c35b0b6fc920fb0722,
    120'h9778397bd097c36b0b6fc9274c91aa, 120'h97b6b97bd19801ec9210c965cc920e,
    120'h97bcf7f1487f531b0b0bb0b6fb0722, 120'h7f0e397bd097c35b0b6fc920fb0722,
    120'h9778397bd097c36b0b6fc9274c91aa, 120'h97b6b97bd19801ec9210c965cc920e,
    120'h97bcf7f1487f531b0b0bb0b6fb0722, 120'h7f0e397bd07f595b0b6fc920fb0722,
    120'h9778397bd097c36b0b6fc9274c91aa, 120'h97b6b97bd19801ec9210c9274c920e,
    120'h97bcf7f0e47f531b0b0bb0b6fb0722, 120'h7f0e397bd07f595b0b0bc920fb0722,
    120'h9778397bd097c36b0b6fc9210c91aa, 120'h97b6b97bd197c36c9210c9274c920e,
    120'h97bcf7f0e47f531b0b0bb0b6fb0722, 120'h7f0e397bd07f595b0b0bc920fb0722,
    120'h9778397bd097c36b0b6fc9210c8dc2, 120'h9778397bd097c36c9210c9274c920e,
    120'h97b6b7f0e47f531b0723b0b6fb0722, 120'h7f0e37f5307f595b0b0bc920fb0722,
    120'h7f0e397bd097c36b0b6fc9210c8dc2, 120'h9778397bd097c36b0b70c9274c91aa,
    120'h97b6b7f0e47f531b0723b0b6fb0721, 120'h7f0e37f1487f595b0b0bb0b6fb0722,
    120'h7f0e397bd097c35b0b6fc9210c8dc2, 120'h9778397bd097c36b0b6fc9274c91aa,
    120'h97b6b7f0e47f531b0723b0b6fb0721, 120'h7f0e27f1487f595b0b0bb0b6fb0722,
    120'h7f0e397bd097c35b0b6fc920fb0722, 120'h9778397bd097c36b0b6fc9274c91aa,
    120'h97b6b7f0e47f531b0723b0b6fb0721, 120'h7f0e27f1487f531b0b0bb0b6fb0722,
    120'h7f0e397bd097c35b0b6fc920fb0722, 120'h9778397bd097c36b0b6fc9274c91aa,
    120'h97b6b7f0e47f531b0723b0b6fb0721, 120'h7f0e27f1487f531b0b0bb0b6fb0722,
    120'h7f0e397bd097c35b0b6fc920fb0722, 120'h9778397bd097c36b0b6fc9274c91aa,
    120'h97b6b7f0e47f531b0723b0b6fb0721, 120'h7f0e27f1487f531b0b0bb0b6fb0722,
    120'h7f0e397bd07f595b0b0bc920fb0722, 120'h9778397bd097c36b0b6fc9274c91aa,
    120'h97b6b7f0e47f531b0723b0787b0721, 120'h7f0e27f0e47f531b0b0bb0b6fb0722,
    120'h7f0e397bd07f595b0b0bc920fb0722, 120'h9778397bd097c36b0b6fc9210c91aa,
    120'h97b6b7f0e47f149b0723b0787b0721, 120'h7f0e27f0e47f531b0723b0b6fb0722,
    120'h7f0e397bd07f595b0b0bc920fb0722, 120'h9778397bd097c36b0b6fc9210c8dc2,
    120'h977837f0e37f149b0723b0787b0721, 120'h7f07e7f0e47f531b0723b0b6fb0722,
    120'h7f0e37f5307f595b0b0bc920fb0722, 120'h7f0e397bd097c35b0b6fc9210c8dc2,
    120'h977837f0e37f14998082b0787b0721, 120'h7f07e7f0e47f531b0723b0b6fb0721,
    120'h7f0e37f1487f595b0b0bb0b6fb0722, 120'h7f0e397bd097c35b0b6fc9210c8dc2,
    120'h977837f0e37f14998082b0787b06bd, 120'h7f07e7f0e47f531b0723b0b6fb0721,
    120'h7f0e27f1487f531b0b0bb0b6fb0722, 120'h7f0e397bd097c35b0b6fc920fb0722,
    120'h977837f0e37f14998082b0787b06bd, 120'h7f07e7f0e47f531b0723b0b6fb0721,
    120'h7f0e27f1487f531b0b0bb0b6fb0722, 120'h7f0e397bd097c35b0b6fc920fb0722,
    120'h977837f0e37f14998082b0787b06bd, 120'h7f07e7f0e47f531b0723b0b6fb0721,
    120'h7f0e27f1487f531b0b0bb0b6fb0722, 120'h7f0e397bd07f595b0b0bc920fb0722,
    120'h977837f0e37f14998082b0787b06bd, 120'h7f07e7f0e47f531b0723b0b6fb0721,
    120'h7f0e27f1487f531b0b0bb0b6fb0722, 120'h7f0e397bd07f595b0b0bc920fb0722,
    120'h977837f0e37f14998082b0787b06bd, 120'h7f07e7f0e47f149b0723b0787b0721,
    120'h7f0e27f0e47f531b0b0bb0b6fb0722, 120'h7f0e397bd07f595b0b0bc920fb0722,
    120'h977837f0e37f14998082b0723b06bd, 120'h7f07e7f0e37f149b0723b0787b0721,
    120'h7f0e27f0e47f531b0723b0b6fb0722, 120'h7f0e397bd07f595b0b0bc920fb0722,
    120'h977837f0e37f14898082b0723b02d5, 120'h7ec967f0e37f14998082b0787b0721,
    120'h7f07e7f0e47f531b0723b0b6fb0722, 120'h7f0e37f1487f595b0b0bb0b6fb0722,
    120'h7f0e37f0e37f14898082b0723b02d5, 120'h7ec967f0e37f14998082b0787b0721,
    120'h7f07e7f0e47f531b0723b0b6fb0722, 120'h7f0e37f1487f531b0b0bb0b6fb0722,
    120'h7f0e37f0e37f14898082b0723b02d5, 120'h7ec967f0e37f14998082b0787b06bd,
    120'h7f07e7f0e47f531b0723b0b6fb0721, 120'h7f0e37f1487f531b0b0bb0b6fb0722,
    120'h7f0e37f0e37f14898082b072297c35, 120'h7ec967f0e37f14998082b0787b06bd,
    120'h7f07e7f0e47f531b0723b0b6fb0721, 120'h7f0e27f1487f531b0b0bb0b6fb0722,
    120'h7f0e37f0e37f14898082b072297c35, 120'h7ec967f0e37f14998082b0787b06bd,
    120'h7f07e7f0e47f531b0723b0b6fb0721, 120'h7f0e27f1487f531b0b0bb0b6fb0722,
    120'h7f0e37f0e366aa89801eb072297c35, 120'h7ec967f0e37f14998082b0787b06bd,
    120'h7f07e7f0e47f149b0723b0787b0721, 120'h7f0e27f1487f531b0b0bb0b6fb0722,
    120'h7f0e37f0e366aa89801eb072297c35, 120'h7ec967f0e37f14998082b0723b06bd,
    120'h7f07e7f0e47f149b0723b0787b0721, 120'h7f0e27f0e47f531b0723b0b6fb0722,
    120'h7f0e37f0e366aa89801eb072297c35, 120'h7ec967f0e37f14998082b0723b06bd,
    120'h7f07e7f0e37f14998083b0787b0721, 120'h7f0e27f0e47f531b0723b0b6fb0722,
    120'h7f0e37f0e366aa89801eb072297c35, 120'h7ec967f0e37f14898082b0723b02d5,
    120'h7f07e7f0e37f14998082b0787b0721, 120'h7f07e7f0e47f531b0723b0b6fb0722,
    120'h7f0e36665b66aa89801e9808297c35, 120'h665f67f0e37f14898082b0723b02d5,
    120'h7ec967f0e37f14998082b0787b0721, 120'h7f07e7f0e47f531b0723b0b6fb0722,
    120'h7f0e36665b66a449801e9808297c35, 120'h665f67f0e37f14898082b0723b02d5,
    120'h7ec967f0e37f14998082b0787b06bd, 120'h7f07e7f0e47f531b0723b0b6fb0721,
    120'h7f0e36665b66a449801e9808297c35, 120'h665f67f0e37f14898082b072297c35,
    120'h7ec967f0e37f14998082b0787b06bd, 120'h7f07e7f0e47f531b0723b0b6fb0721,
    120'h7f0e26665b66a449801e9808297c35, 120'h665f67f0e37f1489801eb072297c35,
    120'h7ec967f0e37f14998082b0787b06bd, 120'h7f07e7f0e47f531b0723b0b6fb0721,
    120'h7f0e27f1487f531b0b0bb0b6fb0722
  };

  // yt is years since FIRST_YEAR; 1900 and 2100 are not leap years
  function automatic logic greg_leap(input logic [7:0] yt);
    return (yt[1:0] == 2'd0) && (yt != 8'd0) && (yt != 8'd200);
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] greg_mdays(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      4'd2:                       r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    r = 5'd30;
      default:                    r = 5'd31;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] year_len(input logic [16:0] w);
    logic [8:0] s;
    s = 9'(BASE_DAYS);
    for (int i = 4; i < 16; i++) begin
      s = s + 9'(w[i]);
    end
    if (w[3:0] != 4'd0) begin
      s = s + (w[16] ? 9'd30 : 9'd29);
    end
    return s;
  endfunction

  function automatic logic [4:0] month_len(input logic [16:0] w, input logic [3:0] m);
    logic [4:0] r;
    r = 5'd29;
    if (m >= 4'd1 && m <= 4'd12) begin
      r = w[5'd16 - 5'(m)] ? 5'd30 : 5'd29;
    end
    return r;
  endfunction

  function automatic logic [19:0] term_group(input logic [119:0] t, input logic [2:0] g);
    logic [19:0] r;
    case (g)
      3'd0:    r = t[119:100];
      3'd1:    r = t[99:80];
      3'd2:    r = t[79:60];
      3'd3:    r = t[59:40];
      3'd4:    r = t[39:20];
      default: r = t[19:0];
    endcase
    return r;
  endfunction

  // divisor shifted to the top step of each job
  function automatic logic [19:0] job_dv(input job_e j);
    logic [19:0] r;
    case (j)
      JOB_KILO: r = 20'd1000 << 10;
      JOB_HUND: r = 20'd100 << 3;
      JOB_MCYC: r = 20'd60 << 5;
      JOB_DCYC: r = 20'd60 << 10;
      JOB_WDAY: r = 20'd7 << 13;
      default:  r = 20'd60 << 2;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] job_last(input job_e j);
    logic [3:0] r;
    case (j)
      JOB_KILO: r = 4'd10;
      JOB_HUND: r = 4'd3;
      JOB_MCYC: r = 4'd5;
      JOB_DCYC: r = 4'd10;
      JOB_WDAY: r = 4'd13;
      default:  r = 4'd2;
    endcase
    return r;
  endfunction

endpackage

/* design/s2l_day_number.sv */
// ----------------------------------------------------------------------------
// s2l_day_number
// Registered count of days from 1 January of the first year to a date.
// ----------------------------------------------------------------------------
module s2l_day_number (
  input  logic        clk_i,
  input  logic [7:0]  yt_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_i,
  output logic [16:0] num_o
);
  import s2l_pkg::*;

  logic [6:0]  leaps;
  logic [16:0] num_d;
  logic [16:0] num_q;

  // leap years in [first year, year-1]; the first year itself is not one
  assign leaps = 7'((9'(yt_i) + 9'd3) >> 2) - 7'(yt_i != 8'd0);

  assign num_d = 17'(yt_i) * 17'd365 + 17'(leaps) + 17'(days_before(month_i))
               + 17'(day_i) - 17'd1
               + 17'((month_i > 4'd2) && greg_leap(yt_i));

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
  end

  assign num_o = num_q;

endmodule

/* design/solar_to_lunar_date.sv */
// ----------------------------------------------------------------------------
// solar_to_lunar_date
// Gregorian date and hour to Chinese lunar date, 1900-01-31 to 2100-12-31.
// ----------------------------------------------------------------------------
// One item is taken when start_i is high and busy_o low; busy_o stays high
// until the result, which sits on the outputs for the single cycle in which
// done_o is high and must be taken then. An item first forms the day count,
// then walks the lunar years from 1900 and the lunar months one at a time,
// then runs 49 steps of the shared restoring divider (term days, month and
// day cycles, weekday, year cycle). A single subtract and compare unit does
// every step. Out of range or impossible dates finish with valid_res_o low
// and every other field zero.
module solar_to_lunar_date (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [11:0] solar_year_i,
  input  logic [3:0]  solar_month_i,
  input  logic [4:0]  solar_day_i,
  input  logic [4:0]  hour_of_day_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [11:0] lunar_year_o,
  output logic [3:0]  lunar_month_o,
  output logic [4:0]  lunar_day_o,
  output logic        leap_month_flag_o,
  output logic [5:0]  year_cycle_o,
  output logic [5:0]  month_cycle_o,
  output logic [5:0]  day_cycle_o,
  output logic [3:0]  hour_branch_o,
  output logic [4:0]  term_index_o,
  output logic [2:0]  weekday_o,
  output logic        valid_res_o
);
  import s2l_pkg::*;

  `include "solar_to_lunar_date_macros.svh"

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DAYN  = 3'd1;
  localparam logic [2:0] ST_CHK   = 3'd2;
  localparam logic [2:0] ST_YEAR  = 3'd3;
  localparam logic [2:0] ST_MONTH = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;

  logic [2:0]  state_q;
  job_e        job_q;
  logic [3:0]  cnt_q;
  logic [19:0] acc_q, dv_q;
  logic [13:0] q_q;
  logic [7:0]  yt_q, yi_q;
  logic [3:0]  m_q, mi_q, hb_q;
  logic [4:0]  d_q, lday_q, term_q;
  logic        dvalid_q, lp_q, done_q;
  logic [5:0]  mcyc_q, dcyc_q;
  logic [2:0]  wday_q;

  logic [11:0] o_year_q;
  logic [3:0]  o_month_q, o_hb_q;
  logic [4:0]  o_day_q, o_term_q;
  logic        o_leap_q, o_valid_q;
  logic [5:0]  o_ycyc_q, o_mcyc_q, o_dcyc_q;
  logic [2:0]  o_wday_q;

  logic [16:0] num;
  logic [7:0]  yt_in, yi_idx;
  logic        in_ok;
  logic [5:0]  h_inc;
  logic [4:0]  h_half;
  logic [3:0]  hb_in;
  logic [16:0] yword;
  logic [4:0]  leap_len;
  logic [19:0] opnd;
  logic [20:0] diff;
  logic        ge;
  logic [19:0] rem;
  logic [13:0] quo;
  logic [19:0] tgroup;
  logic [10:0] kilo_pick;
  logic [3:0]  first_v;
  logic [4:0]  term_v;
  logic [11:0] mc_div;

  s2l_day_number u_dayn (
    .clk_i   (clk_i),
    .yt_i    (yt_q),
    .month_i (m_q),
    .day_i   (d_q),
    .num_o   (num)
  );

  assign yt_in = 8'(solar_year_i - 12'(FIRST_YEAR));
  assign in_ok = (solar_year_i >= 12'(FIRST_YEAR)) && (solar_year_i <= 12'(LAST_YEAR))
              && (solar_month_i >= 4'd1) && (solar_month_i <= 4'd12)
              && (solar_day_i >= 5'd1)
              && (solar_day_i <= greg_mdays(solar_month_i, greg_leap(yt_in)));

  assign h_inc  = 6'(hour_of_day_i) + 6'd1;
  assign h_half = h_inc[5:1];
  assign hb_in  = (h_half >= 5'd12) ? 4'(h_half - 5'd12) : h_half[3:0];

  assign yi_idx   = (yi_q < 8'(YEAR_COUNT)) ? yi_q : 8'd0;
  assign yword    = YEAR_INFO[yi_idx];
  assign leap_len = yword[16] ? 5'd30 : 5'd29;

  // shared subtract and compare
  always_comb begin
    case (state_q)
      ST_YEAR:  opnd = 20'(year_len(yword));
      ST_MONTH: opnd = 20'(lp_q ? leap_len : month_len(yword, mi_q));
      default:  opnd = dv_q;
    endcase
  end
  assign diff = {1'b0, acc_q} - {1'b0, opnd};
  assign ge   = !diff[20];
  assign rem  = ge ? diff[19:0] : acc_q;
  assign quo  = {q_q[12:0], ge};

  assign tgroup    = term_group(TERM_TEXT[yt_q], 3'((m_q - 4'd1) >> 1));
  assign kilo_pick = m_q[0] ? quo[10:0] : rem[10:0];
  assign first_v   = (quo[3:0] >= 4'd10) ? quo[3:0] - 4'd10 : quo[3:0];
  assign term_v    = (5'(rem[6:0]) == d_q && rem[6:5] == 2'd0) ? {m_q, 1'b0}
                   : (5'(first_v) == d_q) ? {m_q, 1'b0} - 5'd1 : 5'd0;
  assign mc_div    = 12'({yt_q, 3'b0}) + 12'({yt_q, 2'b0}) + 12'(m_q)
                   + ((d_q >= 5'(first_v)) ? 12'd12 : 12'd11);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      done_q    <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            yt_q     <= yt_in;
            m_q      <= solar_month_i;
            d_q      <= solar_day_i;
            hb_q     <= hb_in;
            dvalid_q <= in_ok;
            state_q  <= ST_DAYN;
          end
        end
        ST_DAYN: begin
          state_q <= ST_CHK;
        end
        ST_CHK: begin
          if (!dvalid_q || num < 17'(EPOCH_DAY)) begin
            o_year_q  <= '0;
            o_month_q <= '0;
            o_day_q   <= '0;
            o_leap_q  <= 1'b0;
            o_ycyc_q  <= '0;
            o_mcyc_q  <= '0;
            o_dcyc_q  <= '0;
            o_hb_q    <= '0;
            o_term_q  <= '0;
            o_wday_q  <= '0;
            o_valid_q <= 1'b0;
            done_q    <= 1'b1;
            state_q   <= ST_IDLE;
          end else begin
            acc_q   <= 20'(num - 17'(EPOCH_DAY));
            yi_q    <= '0;
            state_q <= ST_YEAR;
          end
        end
        ST_YEAR: begin
          if (yi_q == 8'(YEAR_COUNT)) begin
            o_year_q  <= '0;
            o_month_q <= '0;
            o_day_q   <= '0;
            o_leap_q  <= 1'b0;
            o_ycyc_q  <= '0;
            o_mcyc_q  <= '0;
            o_dcyc_q  <= '0;
            o_hb_q    <= '0;
            o_term_q  <= '0;
            o_wday_q  <= '0;
            o_valid_q <= 1'b0;
            done_q    <= 1'b1;
            state_q   <= ST_IDLE;
          end else if (ge) begin
            acc_q <= diff[19:0];
            yi_q  <= yi_q + 8'd1;
          end else begin
            mi_q    <= 4'd1;
            lp_q    <= 1'b0;
            state_q <= ST_MONTH;
          end
        end
        ST_MONTH: begin
          if (ge) begin
            acc_q <= diff[19:0];
            if (!lp_q && mi_q == yword[3:0]) begin
              lp_q <= 1'b1;
            end else begin
              lp_q <= 1'b0;
              mi_q <= mi_q + 4'd1;
            end
          end else begin
            lday_q  <= 5'(acc_q) + 5'd1;
            acc_q   <= tgroup;
            job_q   <= JOB_KILO;
            dv_q    <= job_dv(JOB_KILO);
            cnt_q   <= job_last(JOB_KILO);
            q_q     <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          acc_q <= rem;
          q_q   <= quo;
          dv_q  <= dv_q >> 1;
          cnt_q <= cnt_q - 4'd1;
          if (cnt_q == 4'd0) begin
            q_q <= '0;
            case (job_q)
              JOB_KILO: begin
                acc_q <= 20'(kilo_pick);
                job_q <= JOB_HUND;
                dv_q  <= job_dv(JOB_HUND);
                cnt_q <= job_last(JOB_HUND);
              end
              JOB_HUND: begin
                term_q  <= term_v;
                acc_q   <= 20'(mc_div);
                job_q   <= JOB_MCYC;
                dv_q    <= job_dv(JOB_MCYC);
                cnt_q   <= job_last(JOB_MCYC);
              end
              JOB_MCYC: begin
                mcyc_q <= rem[5:0];
                acc_q  <= 20'(num) + 20'd10;
                job_q  <= JOB_DCYC;
                dv_q   <= job_dv(JOB_DCYC);
                cnt_q  <= job_last(JOB_DCYC);
              end
              JOB_DCYC: begin
                dcyc_q <= rem[5:0];
                acc_q  <= 20'(num);
                job_q  <= JOB_WDAY;
                dv_q   <= job_dv(JOB_WDAY);
                cnt_q  <= job_last(JOB_WDAY);
              end
              JOB_WDAY: begin
                wday_q <= rem[2:0] + 3'd1;
                acc_q  <= 20'(yi_q) + 20'(YC_BIAS);
                job_q  <= JOB_YCYC;
                dv_q   <= job_dv(JOB_YCYC);
                cnt_q  <= job_last(JOB_YCYC);
              end
              default: begin
                o_year_q  <= 12'(FIRST_YEAR) + 12'(yi_q);
                o_month_q <= mi_q;
                o_day_q   <= lday_q;
                o_leap_q  <= lp_q;
                o_ycyc_q  <= rem[5:0];
                o_mcyc_q  <= mcyc_q;
                o_dcyc_q  <= dcyc_q;
                o_hb_q    <= hb_q;
                o_term_q  <= term_q;
                o_wday_q  <= wday_q;
                o_valid_q <= 1'b1;
                done_q    <= 1'b1;
                state_q   <= ST_IDLE;
              end
            endcase
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o            = (state_q != ST_IDLE);
  assign done_o            = done_q;
  assign lunar_year_o      = o_year_q;
  assign lunar_month_o     = o_month_q;
  assign lunar_day_o       = o_day_q;
  assign leap_month_flag_o = o_leap_q;
  assign year_cycle_o      = o_ycyc_q;
  assign month_cycle_o     = o_mcyc_q;
  assign day_cycle_o       = o_dcyc_q;
  assign hour_branch_o     = o_hb_q;
  assign term_index_o      = o_term_q;
  assign weekday_o         = o_wday_q;
  assign valid_res_o       = o_valid_q;

  `S2L_ASSERT(a_done_idle, done_o |-> !busy_o, "result shown while still busy")
  `S2L_ASSERT(a_start_busy, (start_i && !busy_o) |=> busy_o, "item taken but not busy")
  `S2L_ASSERT(a_day_range, (done_o && valid_res_o) |-> (lunar_day_o != 5'd0 && lunar_day_o <= 5'd30), "lunar day out of range")
  `S2L_ASSERT(a_bad_zero, (done_o && !valid_res_o) |-> (lunar_year_o == 12'd0 && weekday_o == 3'd0), "invalid result not cleared")
  `S2L_ASSERT(a_month_year, (state_q == ST_MONTH) |-> (yi_q < 8'(YEAR_COUNT)), "month walk past table end")
  `S2L_ASSERT_ALWAYS(a_done_pulse, done_o |=> !done_o, "done held for more than one cycle")

endmodule
